[sv/bmpp_pkg.sv]
// ----------------------------------------------------------------------------
// bmpp_pkg
// Shared types and codes for the bitmap pixel row packer.
// ----------------------------------------------------------------------------
package bmpp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    FMT_BGR24   = 2'd0,
    FMT_BGR32   = 2'd1,
    FMT_FIELD16 = 2'd2,
    FMT_FIELD32 = 2'd3
  } pix_fmt_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_RED_BITS     = 3'd1,
    REG_GREEN_BITS   = 3'd2,
    REG_BLUE_BITS    = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    pix_fmt_t    pixel_format;
    logic [5:0]  red_bits;
    logic [5:0]  green_bits;
    logic [5:0]  blue_bits;
    logic [15:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
  } pixel_t;

  typedef struct packed {
    logic [31:0] byte_lanes;
    logic [2:0]  byte_count;
    logic        is_padding;
    logic        last_of_item;
    logic        status;
  } result_t;

  // encoder output toward the sequencer
  typedef struct packed {
    logic [31:0] lanes;
    logic [2:0]  count;
    logic        err;
  } enc_t;

endpackage

[sv/bmpp_pixel_if.sv]
// ----------------------------------------------------------------------------
// bmpp_pixel_if
// Valid/ready channel carrying one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface bmpp_pixel_if import bmpp_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/bmpp_result_if.sv]
// ----------------------------------------------------------------------------
// bmpp_result_if
// Valid/ready channel carrying one group of output bytes per beat.
// ----------------------------------------------------------------------------
interface bmpp_result_if import bmpp_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/bmpp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bmpp_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bmpp_cfg_regs import bmpp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: cfg_nxt.pixel_format = pix_fmt_t'(cfg_wdata[1:0]);
        REG_RED_BITS:     cfg_nxt.red_bits     = cfg_wdata[5:0];
        REG_GREEN_BITS:   cfg_nxt.green_bits   = cfg_wdata[5:0];
        REG_BLUE_BITS:    cfg_nxt.blue_bits    = cfg_wdata[5:0];
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_wdata;
        default:          cfg_nxt = cfg_r;   // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format <= FMT_BGR24;
      cfg_r.red_bits     <= 6'd5;
      cfg_r.green_bits   <= 6'd5;
      cfg_r.blue_bits    <= 6'd5;
      cfg_r.image_width  <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/bmpp_chan_scale.sv]
// ----------------------------------------------------------------------------
// bmpp_chan_scale
// Scales an 8-bit channel to k bits as ceil(v*(2^k-1)/255), no divider.
// ----------------------------------------------------------------------------
module bmpp_chan_scale (
  input  logic [7:0]  chan_value,
  input  logic [5:0]  field_bits,
  output logic [31:0] field_value
);

  // v/255 is v repeated in 8-bit groups after the binary point, so
  // floor(v*2^k/255) is the top k bits of that pattern. The leftover
  // fraction is rotl(v,k)/255; subtracting v/255 gives the ceil bump.
  logic [39:0] rep;
  logic [5:0]  shamt;
  logic [39:0] top;
  logic [15:0] dbl;
  logic [7:0]  rot;

  always_comb begin
    rep         = {5{chan_value}};
    shamt       = 6'd40 - field_bits;
    top         = rep >> shamt;
    dbl         = {chan_value, chan_value} << field_bits[2:0];
    rot         = dbl[15:8];
    field_value = top[31:0] + {31'd0, (rot > chan_value)};
  end

endmodule

[sv/bmpp_pixel_encode.sv]
// ----------------------------------------------------------------------------
// bmpp_pixel_encode
// Builds the little-endian byte lanes of one pixel for the current format.
// ----------------------------------------------------------------------------
module bmpp_pixel_encode import bmpp_pkg::*; (
  input  pixel_t pix,
  input  cfg_t   cfg,
  output enc_t   enc
);

  logic [31:0] red_f;
  logic [31:0] green_f;
  logic [31:0] blue_f;
  logic [7:0]  bits_sum;
  logic [6:0]  red_shift;
  logic [31:0] word;

  bmpp_chan_scale u_red (
    .chan_value (pix.red_value),
    .field_bits (cfg.red_bits),
    .field_value(red_f)
  );

  bmpp_chan_scale u_green (
    .chan_value (pix.green_value),
    .field_bits (cfg.green_bits),
    .field_value(green_f)
  );

  bmpp_chan_scale u_blue (
    .chan_value (pix.blue_value),
    .field_bits (cfg.blue_bits),
    .field_value(blue_f)
  );

  always_comb begin
    bits_sum  = {2'b00, cfg.red_bits} + {2'b00, cfg.green_bits} + {2'b00, cfg.blue_bits};
    red_shift = {1'b0, cfg.green_bits} + {1'b0, cfg.blue_bits};
    word      = (red_f << red_shift) | (green_f << cfg.blue_bits) | blue_f;
    enc       = '0;
    unique case (cfg.pixel_format)
      FMT_BGR24: begin
        enc.lanes = {8'h00, pix.red_value, pix.green_value, pix.blue_value};
        enc.count = 3'd3;
      end
      FMT_BGR32: begin
        enc.lanes = {8'h00, pix.red_value, pix.green_value, pix.blue_value};
        enc.count = 3'd4;
      end
      FMT_FIELD16: begin
        if (bits_sum > 8'd16) begin
          enc.err = 1'b1;
        end else begin
          enc.lanes = {16'h0000, word[15:0]};
          enc.count = 3'd2;
        end
      end
      FMT_FIELD32: begin
        if (bits_sum > 8'd32) begin
          enc.err = 1'b1;
        end else begin
          enc.lanes = word;
          enc.count = 3'd4;
        end
      end
      default: enc = '0;
    endcase
  end

endmodule

[sv/bmp_pixel_row_packer_unit.sv]
// ----------------------------------------------------------------------------
// bmp_pixel_row_packer_unit
// Packs RGB pixels into bitmap pixel-array bytes with row-end padding.
// ----------------------------------------------------------------------------
// One pixel is taken per beat into the input register, then encoded; its
// bytes land in the output register once that register is free. A new
// pixel is accepted every cycle while the output is not stalled.
// A pixel that ends a row and needs padding (24-bit with width mod 4 not
// zero, 16-bit with odd width) gives a second result, a zero-padding beat,
// through the single output register, and stays in the input register
// until that beat goes out. Unsupported field lengths give one status beat
// and leave the column count alone. Configuration must be written only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module bmp_pixel_row_packer_unit import bmpp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  bmpp_pixel_if.sink          in_chan,
  bmpp_result_if.source       out_chan,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t        cfg;
  enc_t        enc;

  logic        s1_valid_r, s1_valid_nxt;
  pixel_t      s1_pix_r, s1_pix_nxt;
  logic        pad_pend_r, pad_pend_nxt;
  logic [2:0]  pad_len_r, pad_len_nxt;
  logic [15:0] col_r, col_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r, out_res_nxt;

  logic        out_free;
  logic        s1_done;
  logic        in_take;
  logic [15:0] w_eff;
  logic [16:0] col_inc;
  logic        row_end;
  logic [2:0]  pad;

  bmpp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  bmpp_pixel_encode u_enc (
    .pix(s1_pix_r),
    .cfg(cfg),
    .enc(enc)
  );

  always_comb begin
    w_eff   = (cfg.image_width == 16'd0) ? 16'd1 : cfg.image_width;
    col_inc = {1'b0, col_r} + 17'd1;
    row_end = col_inc >= {1'b0, w_eff};
    pad     = 3'd0;
    if (row_end) begin
      if (cfg.pixel_format == FMT_BGR24) begin
        pad = {1'b0, w_eff[1:0]};
      end else if (cfg.pixel_format == FMT_FIELD16 && w_eff[0]) begin
        pad = 3'd2;
      end
    end

    out_free = !out_valid_r || out_chan.ready;
    s1_done  = out_free && (pad_pend_r || (s1_valid_r && (enc.err || pad == 3'd0)));
    in_take  = in_chan.valid && (!s1_valid_r || s1_done);

    s1_valid_nxt  = s1_valid_r;
    s1_pix_nxt    = s1_pix_r;
    pad_pend_nxt  = pad_pend_r;
    pad_len_nxt   = pad_len_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_res_nxt   = out_res_r;

    if (pad_pend_r && out_free) begin
      // second beat of a row-end pixel: zero padding
      out_valid_nxt           = 1'b1;
      out_res_nxt.byte_lanes  = 32'd0;
      out_res_nxt.byte_count  = pad_len_r;
      out_res_nxt.is_padding  = 1'b1;
      out_res_nxt.last_of_item = 1'b1;
      out_res_nxt.status      = 1'b0;
      pad_pend_nxt            = 1'b0;
    end else if (s1_valid_r && out_free) begin
      out_valid_nxt           = 1'b1;
      out_res_nxt.byte_lanes  = enc.lanes;
      out_res_nxt.byte_count  = enc.count;
      out_res_nxt.is_padding  = 1'b0;
      out_res_nxt.status      = enc.err;
      if (enc.err) begin
        out_res_nxt.last_of_item = 1'b1;
      end else begin
        out_res_nxt.last_of_item = (pad == 3'd0);
        col_nxt      = row_end ? 16'd0 : col_inc[15:0];
        pad_pend_nxt = (pad != 3'd0);
        pad_len_nxt  = pad;
      end
    end

    if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_pix_nxt   = in_chan.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pad_pend_r  <= 1'b0;
      col_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pad_pend_r  <= pad_pend_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r  <= s1_pix_nxt;
    pad_len_r <= pad_len_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_chan.ready  = !s1_valid_r || s1_done;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_res_r;

endmodule

[test/tb_bmp_pixel_row_packer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bmp_pixel_row_packer_unit
// Self-checking bench for the bitmap pixel row packer.
// ----------------------------------------------------------------------------
// A short table of directed pixels covers the four formats, field extremes,
// unsupported field lengths, zero and maximum widths and a width shrunk in
// the middle of a row. Random phases follow, each starting from an idle
// block, most with a new register setting. Each accepted pixel's beats,
// from a local packer model or typed in its row, are queued and compared
// field by field with the output. Both channels stall in short random bursts.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_row_packer_unit;
  import bmpp_pkg::*;

  localparam int RandItems     = 1700;
  localparam int CalmItems     = 200;    // final stretch without idling
  localparam int SettleCycles  = 4;
  localparam int StallLimit    = 400;
  localparam int FirstUnusedReg = 5;
  localparam int LastUnusedReg  = 7;
  localparam result_t NoRes    = '0;

  typedef struct {
    cfg_t    cfg;
    pixel_t  px;
    int      n_typed;   // 0: take the model's beats
    result_t t0;
    result_t t1;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  bmpp_pixel_if  in_chan ();
  bmpp_result_if out_chan ();

  bmp_pixel_row_packer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cfg_t      cur_cfg;
  int        col_pos;
  result_t   pending_beats[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  int        idle_en;
  int        stall_left;
  int        quiet_cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // packer model
  // --------------------------------------------------------------------------
  function automatic logic [63:0] scale_ch(logic [7:0] v, logic [5:0] k);
    logic [63:0] top;
    if (k == 0) return 64'd0;
    top = (64'd1 << k) - 64'd1;
    return (64'(v) * top + 64'd254) / 64'd255;
  endfunction

  function automatic int pack_pixel(input pixel_t px, output result_t r0, output result_t r1);
    int          w, depth, sum, pad;
    logic [63:0] word;
    logic [31:0] lanes;
    logic [2:0]  count;
    r0 = '0;
    r1 = '0;
    w = (cur_cfg.image_width == 0) ? 1 : int'(cur_cfg.image_width);
    pad = 0;
    if (cur_cfg.pixel_format == FMT_BGR24 || cur_cfg.pixel_format == FMT_BGR32) begin
      lanes = {8'h00, px.red_value, px.green_value, px.blue_value};
      count = (cur_cfg.pixel_format == FMT_BGR24) ? 3'd3 : 3'd4;
    end else begin
      depth = (cur_cfg.pixel_format == FMT_FIELD16) ? 16 : 32;
      sum = int'(cur_cfg.red_bits) + int'(cur_cfg.green_bits) + int'(cur_cfg.blue_bits);
      if (sum > depth) begin
        // status beat, column left alone
        r0.last_of_item = 1'b1;
        r0.status = 1'b1;
        return 1;
      end
      word = (scale_ch(px.red_value, cur_cfg.red_bits)
               << (int'(cur_cfg.blue_bits) + int'(cur_cfg.green_bits)))
           | (scale_ch(px.green_value, cur_cfg.green_bits) << cur_cfg.blue_bits)
           | scale_ch(px.blue_value, cur_cfg.blue_bits);
      lanes = (depth == 16) ? {16'h0000, word[15:0]} : word[31:0];
      count = 3'(depth / 8);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (cur_cfg.pixel_format == FMT_BGR24) pad = w % 4;
      else if (cur_cfg.pixel_format == FMT_FIELD16 && (w % 2) == 1) pad = 2;
    end else begin
      col_pos = col_pos + 1;
    end
    r0.byte_lanes = lanes;
    r0.byte_count = count;
    r0.last_of_item = (pad == 0);
    if (pad == 0) return 1;
    r1.byte_count = 3'(pad);
    r1.is_padding = 1'b1;
    r1.last_of_item = 1'b1;
    return 2;
  endfunction

  // --------------------------------------------------------------------------
  // table helpers
  // --------------------------------------------------------------------------
  function automatic cfg_t mk_cfg(pix_fmt_t f, int rb, int gb, int bb, int w);
    cfg_t c;
    c.pixel_format = f;
    c.red_bits = 6'(rb);
    c.green_bits = 6'(gb);
    c.blue_bits = 6'(bb);
    c.image_width = 16'(w);
    return c;
  endfunction

  function automatic result_t mk_res(logic [31:0] lanes, int cnt, bit pad, bit last, bit st);
    result_t r;
    r.byte_lanes = lanes;
    r.byte_count = 3'(cnt);
    r.is_padding = pad;
    r.last_of_item = last;
    r.status = st;
    return r;
  endfunction

  function automatic void add_row(cfg_t c, pixel_t px, int nt, result_t t0, result_t t1);
    stim_row_t row;
    row.cfg = c;
    row.px = px;
    row.n_typed = nt;
    row.t0 = t0;
    row.t1 = t1;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(1, 9));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    logic [15:0] data, keep;
    case (idx)
      REG_PIXEL_FORMAT: keep = 16'h0003;
      REG_RED_BITS, REG_GREEN_BITS, REG_BLUE_BITS: keep = 16'h003F;
      default: keep = 16'hFFFF;
    endcase
    data = 16'(value) & keep;
    // junk above the register width must be dropped
    if ($urandom_range(0, 1) == 1) data |= 16'($urandom) & ~keep;
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      REG_PIXEL_FORMAT: cur_cfg.pixel_format = pix_fmt_t'(data[1:0]);
      REG_RED_BITS:     cur_cfg.red_bits = data[5:0];
      REG_GREEN_BITS:   cur_cfg.green_bits = data[5:0];
      REG_BLUE_BITS:    cur_cfg.blue_bits = data[5:0];
      REG_IMAGE_WIDTH:  cur_cfg.image_width = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_pixel(input pixel_t px, input int n_typed, input result_t t0,
                            input result_t t1);
    result_t p0, p1;
    int      n;
    @(negedge clk);
    if (idle_en != 0 && $urandom_range(0, 3) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.data = px;
    do @(posedge clk); while (!in_chan.ready);
    n = pack_pixel(px, p0, p1);
    if (n_typed > 0) begin
      pending_beats.push_back(t0);
      if (n_typed > 1) pending_beats.push_back(t1);
    end else begin
      pending_beats.push_back(p0);
      if (n == 2) pending_beats.push_back(p1);
    end
  endtask

  // stop sending and let every queued beat come out
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // result side: random backpressure bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_chan.ready = 1'b0;
    end else if (rst_n && idle_en != 0 && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_chan.ready = 1'b0;
    end else begin
      out_chan.ready = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_beat
    result_t want, got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.data;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_beats.pop_front();
        if (got.byte_lanes !== want.byte_lanes) begin
          $display("%0t: byte_lanes expected %h got %h", $time, want.byte_lanes,
                   got.byte_lanes);
          mismatch_count++;
        end
        if (got.byte_count !== want.byte_count) begin
          $display("%0t: byte_count expected %0d got %0d", $time, want.byte_count,
                   got.byte_count);
          mismatch_count++;
        end
        if (got.is_padding !== want.is_padding) begin
          $display("%0t: is_padding expected %b got %b", $time, want.is_padding,
                   got.is_padding);
          mismatch_count++;
        end
        if (got.last_of_item !== want.last_of_item) begin
          $display("%0t: last_of_item expected %b got %b", $time, want.last_of_item,
                   got.last_of_item);
          mismatch_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %b got %b", $time, want.status, got.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         sent, n, kind, fmt_i, depth, s, a, b2, c, rot;
    logic [5:0] bits [3];
    pixel_t     px;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    mismatch_count = 0;
    idle_en = 1;
    col_pos = 0;
    cur_cfg = mk_cfg(FMT_BGR24, 5, 5, 5, 1);

    // first row runs on the reset setting
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 1), 24'h123456, 2,
            mk_res(32'h00123456, 3, 0, 0, 0), mk_res(0, 1, 1, 1, 0));
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 1), 24'hFFFFFF, 2,
            mk_res(32'h00FFFFFF, 3, 0, 0, 0), mk_res(0, 1, 1, 1, 0));
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 1), 24'h000000, 2,
            mk_res(0, 3, 0, 0, 0), mk_res(0, 1, 1, 1, 0));
    add_row(mk_cfg(FMT_BGR32, 5, 5, 5, 1), 24'hFFFFFF, 1,
            mk_res(32'h00FFFFFF, 4, 0, 1, 0), NoRes);
    add_row(mk_cfg(FMT_BGR32, 5, 5, 5, 1), 24'h000000, 1, mk_res(0, 4, 0, 1, 0), NoRes);
    add_row(mk_cfg(FMT_FIELD16, 5, 5, 5, 1), 24'hFFFFFF, 2,
            mk_res(32'h00007FFF, 2, 0, 0, 0), mk_res(0, 2, 1, 1, 0));
    add_row(mk_cfg(FMT_FIELD16, 5, 6, 5, 2), 24'h804001, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_FIELD16, 5, 6, 5, 2), 24'h3FC07E, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_FIELD16, 6, 6, 6, 2), 24'hFFFFFF, 1, mk_res(0, 0, 0, 1, 1), NoRes);
    add_row(mk_cfg(FMT_FIELD16, 0, 0, 0, 3), 24'hFFFFFF, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_FIELD32, 8, 8, 8, 3), 24'hA55AC3, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_FIELD32, 32, 0, 0, 3), 24'hFFFFFF, 1,
            mk_res(32'hFFFFFFFF, 4, 0, 1, 0), NoRes);
    add_row(mk_cfg(FMT_FIELD32, 0, 0, 32, 3), 24'hFFFFFF, 1,
            mk_res(32'hFFFFFFFF, 4, 0, 1, 0), NoRes);
    add_row(mk_cfg(FMT_FIELD32, 11, 11, 11, 3), 24'h123456, 1,
            mk_res(0, 0, 0, 1, 1), NoRes);
    add_row(mk_cfg(FMT_FIELD32, 1, 1, 1, 3), 24'h0100FF, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_FIELD32, 10, 11, 11, 3), 24'h7F80FE, 0, NoRes, NoRes);
    // width zero acts as one pixel per row
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 0), 24'h00FF00, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_FIELD16, 5, 5, 5, 0), 24'hFF00FF, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 65535), 24'h102030, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 65535), 24'h405060, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 65535), 24'h708090, 0, NoRes, NoRes);
    // width cut below the current column: next pixel closes the row
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 2), 24'hA0B0C0, 0, NoRes, NoRes);
    add_row(mk_cfg(FMT_BGR24, 5, 5, 5, 6), 24'h0F0F0F, 0, NoRes, NoRes);
    // field lengths do not matter outside the bit-field formats
    add_row(mk_cfg(FMT_BGR32, 63, 63, 63, 6), 24'hFF00FF, 1,
            mk_res(32'h00FF00FF, 4, 0, 1, 0), NoRes);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != cur_cfg) begin
        drain_results();
        if (directed_rows[i].cfg.pixel_format != cur_cfg.pixel_format)
          write_reg(REG_PIXEL_FORMAT, directed_rows[i].cfg.pixel_format);
        if (directed_rows[i].cfg.red_bits != cur_cfg.red_bits)
          write_reg(REG_RED_BITS, directed_rows[i].cfg.red_bits);
        if (directed_rows[i].cfg.green_bits != cur_cfg.green_bits)
          write_reg(REG_GREEN_BITS, directed_rows[i].cfg.green_bits);
        if (directed_rows[i].cfg.blue_bits != cur_cfg.blue_bits)
          write_reg(REG_BLUE_BITS, directed_rows[i].cfg.blue_bits);
        if (directed_rows[i].cfg.image_width != cur_cfg.image_width)
          write_reg(REG_IMAGE_WIDTH, directed_rows[i].cfg.image_width);
      end
      send_pixel(directed_rows[i].px, directed_rows[i].n_typed, directed_rows[i].t0,
                 directed_rows[i].t1);
    end

    // writes to unmapped indexes must leave the setting alone
    drain_results();
    for (int idx = FirstUnusedReg; idx <= LastUnusedReg; idx++)
      write_reg(CfgIdxW'(idx), $urandom);

    sent = 0;
    while (sent < RandItems) begin
      drain_results();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // width only; column carries over, may land past the new width
        write_reg(REG_IMAGE_WIDTH, pick_width());
      end else if (kind == 1) begin
        write_reg(CfgIdxW'($urandom_range(FirstUnusedReg, LastUnusedReg)), $urandom);
      end else if (kind >= 3) begin
        fmt_i = $urandom_range(0, 3);
        depth = (fmt_i == FMT_FIELD16) ? 16 : 32;
        s = ($urandom_range(0, 1) == 1) ? depth : $urandom_range(0, depth);
        a = $urandom_range(0, s);
        b2 = $urandom_range(0, s - a);
        c = s - a - b2;
        rot = $urandom_range(0, 2);
        bits[rot] = 6'(a);
        bits[(rot + 1) % 3] = 6'(b2);
        bits[(rot + 2) % 3] = 6'(c);
        if ($urandom_range(0, 7) == 0) begin
          foreach (bits[j]) bits[j] = 6'($urandom);
        end
        write_reg(REG_PIXEL_FORMAT, fmt_i);
        write_reg(REG_RED_BITS, bits[0]);
        write_reg(REG_GREEN_BITS, bits[1]);
        write_reg(REG_BLUE_BITS, bits[2]);
        write_reg(REG_IMAGE_WIDTH, pick_width());
      end
      // kind 2: plain pause with no register change
      idle_en = int'((sent < RandItems - CalmItems) && ($urandom_range(0, 4) != 0));
      n = $urandom_range(4, 50);
      repeat (n) begin
        px = pixel_t'($urandom);
        case ($urandom_range(0, 7))
          0: px = '0;
          1: px = '1;
          default: ;
        endcase
        send_pixel(px, 0, NoRes, NoRes);
        sent++;
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
sv/bmpp_pkg.sv
sv/bmpp_pixel_if.sv
sv/bmpp_result_if.sv
sv/bmpp_cfg_regs.sv
sv/bmpp_chan_scale.sv
sv/bmpp_pixel_encode.sv
sv/bmp_pixel_row_packer_unit.sv
test/tb_bmp_pixel_row_packer_unit.sv
